### sv/telnet_option_refusing_rx_filter_core_defines.svh
// assertion macros for the telnet rx filter checker
// no dependencies; taken in by include where assertions are written
`ifndef TELNET_OPTION_REFUSING_RX_FILTER_CORE_DEFINES_SVH
`define TELNET_OPTION_REFUSING_RX_FILTER_CORE_DEFINES_SVH

// clocked assertion, quiet while reset is asserted
`define TORF_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also watches reset cycles
`define TORF_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/torf_pkg.sv
// shared types and codes for the telnet option refusing rx filter
// no dependencies; imported by the front, queue, back and top modules of the block
package torf_pkg;

    // telnet command codes
    localparam logic [7:0] CODE_IAC  = 8'hFF;
    localparam logic [7:0] CODE_WILL = 8'hFB;
    localparam logic [7:0] CODE_WONT = 8'hFC;
    localparam logic [7:0] CODE_DO   = 8'hFD;
    localparam logic [7:0] CODE_DONT = 8'hFE;
    localparam logic [7:0] CODE_CR   = 8'h0D;

    // default depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // receive parse state
    typedef enum logic [1:0] {
        PS_NORMAL = 2'd0,
        PS_IAC    = 2'd1,
        PS_REFUSE = 2'd2,
        PS_DENY   = 2'd3
    } t_parse_state;

    // beat of a three-byte negotiation reply
    typedef enum logic [1:0] {
        BEAT_IAC    = 2'd0,
        BEAT_VERB   = 2'd1,
        BEAT_OPTION = 2'd2
    } t_beat;

    // one queued job: a data byte or a reply iac verb option
    typedef struct packed {
        logic       is_reply;
        logic [7:0] verb;
        logic [7:0] value;
    } t_cmd;

    // queue fill flags seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### sv/torf_front.sv
// front end: accepts received bytes, runs the telnet parse state
// and pushes data or reply jobs; depends on torf_pkg
module torf_front import torf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_parse_state r_state;
    t_parse_state n_state;
    logic         w_accept;

    // take a byte whenever the queue has room
    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;

    // parse state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_NORMAL;
        end else begin
            r_state <= n_state;
        end
    end

    // classify the byte against the current state
    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            PS_NORMAL: begin
                if (i_data == CODE_IAC) begin
                    n_state = PS_IAC;
                end else if (i_data != CODE_CR) begin
                    o_push      = 1'b1;
                    o_cmd.value = i_data;
                end
            end
            PS_IAC: begin
                unique case (i_data) inside
                    CODE_IAC: begin
                        o_push      = 1'b1;
                        o_cmd.value = CODE_IAC;
                        n_state     = PS_NORMAL;
                    end
                    CODE_WILL, CODE_WONT: n_state = PS_REFUSE;
                    CODE_DO, CODE_DONT:   n_state = PS_DENY;
                    default:              n_state = PS_NORMAL;
                endcase
            end
            PS_REFUSE: begin
                o_push         = 1'b1;
                o_cmd.is_reply = 1'b1;
                o_cmd.verb     = CODE_DONT;
                o_cmd.value    = i_data;
                n_state        = PS_NORMAL;
            end
            PS_DENY: begin
                o_push         = 1'b1;
                o_cmd.is_reply = 1'b1;
                o_cmd.verb     = CODE_WONT;
                o_cmd.value    = i_data;
                n_state        = PS_NORMAL;
            end
            default: n_state = PS_NORMAL;
        endcase
        // nothing moves without a handshake
        if (!w_accept) begin
            n_state = r_state;
            o_push  = 1'b0;
        end
    end

endmodule

### sv/torf_queue.sv
// short job queue that decouples the parser from the output sequencer
// depends on torf_pkg for the job and status types
module torf_queue import torf_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### sv/torf_back.sv
// back end: turns queued jobs into output words, one word per cycle while the
// output is not stalled, through a registered output stage; depends on torf_pkg
module torf_back import torf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_kind,
    output logic       o_last
);

    t_beat      r_beat;
    t_beat      n_beat;
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       r_kind;
    logic       n_kind;
    logic       r_last;
    logic       n_last;
    logic       w_load;

    // output register is free when empty or being taken
    assign w_load  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat  <= BEAT_IAC;
            r_valid <= 1'b0;
        end else begin
            r_beat  <= n_beat;
            r_valid <= n_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_kind <= n_kind;
        r_last <= n_last;
    end

    // sequence the head job into words
    always_comb begin
        n_beat  = r_beat;
        n_valid = r_valid && !i_ready;
        n_byte  = r_byte;
        n_kind  = r_kind;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (w_load && !i_q_status.empty) begin
            n_valid = 1'b1;
            if (!i_head.is_reply) begin
                n_byte = i_head.value;
                n_kind = 1'b0;
                n_last = 1'b1;
                o_pop  = 1'b1;
            end else begin
                n_kind = 1'b1;
                unique case (r_beat)
                    BEAT_IAC: begin
                        n_byte = CODE_IAC;
                        n_last = 1'b0;
                        n_beat = BEAT_VERB;
                    end
                    BEAT_VERB: begin
                        n_byte = i_head.verb;
                        n_last = 1'b0;
                        n_beat = BEAT_OPTION;
                    end
                    BEAT_OPTION: begin
                        n_byte = i_head.value;
                        n_last = 1'b1;
                        n_beat = BEAT_IAC;
                        o_pop  = 1'b1;
                    end
                    default: begin
                        n_valid = r_valid && !i_ready;
                        n_beat  = BEAT_IAC;
                    end
                endcase
            end
        end
    end

endmodule

### sv/telnet_option_refusing_rx_filter_core.sv
// an accepted byte's job is written into the job queue, then loaded into the registered output stage
// throughput: one input byte per cycle while the job queue has room; an option byte
// gives a three-word reply, which holds the output while the job queue absorbs input
// the input stalls only when the job queue fills behind a slow or busy output
// reset (i_rst_n low, synchronous) returns the parser to normal data state and
// empties the queue and the output stage
module telnet_option_refusing_rx_filter_core import torf_pkg::*; #(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] out_kind
    output logic       o_m_axis_tlast
);

    t_q_status w_q_status;
    t_cmd      w_push_cmd;
    t_cmd      w_head;
    logic      w_push;
    logic      w_pop;

    // parser
    torf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_data     (i_s_axis_tdata),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // job queue
    torf_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // output sequencer
    torf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_byte     (o_m_axis_tdata),
        .o_kind     (o_m_axis_tuser),
        .o_last     (o_m_axis_tlast)
    );

endmodule

### sv/torf_checker.sv
// port-level checks for the telnet rx filter, bound to the top level
// depends on telnet_option_refusing_rx_filter_core_defines.svh
`include "telnet_option_refusing_rx_filter_core_defines.svh"

module torf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // a stalled output word stays offered
    `TORF_ASSERT_RST(a_out_valid_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid,
        "output valid dropped while stalled")

    // a stalled output word keeps its payload
    `TORF_ASSERT_RST(a_out_payload_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready
            |=> $stable({o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast}),
        "output payload changed while stalled")

    // a console data word is always the only word of its byte
    `TORF_ASSERT_RST(a_data_is_last, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tlast,
        "data word without last")

    // reset empties the output stage
    `TORF_ASSERT(a_reset_clears_out, i_clk,
        !i_rst_n |=> !o_m_axis_tvalid,
        "output valid after reset")

endmodule

bind telnet_option_refusing_rx_filter_core torf_checker u_torf_checker (.*);
